[hdl/tcpop_pkg.sv]
// Package for the TCP options parser: parser state and result types,
// option kind codes, parse phase codes and defaults.
// No dependencies; used by tcpop_step and tcp_option_parser_unit.
package tcpop_pkg;

  // Default cap on the options area length, in bytes
  localparam int MAX_OPTION_BYTES_DEF = 40;

  // Request codes carried in req_type
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // Option kinds handled natively
  localparam logic [7:0] KIND_EOL = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_MSS = 8'd2;

  // Bytes taken by the kind and length fields of a multi-byte option
  localparam logic [7:0] OPT_HDR_BYTES = 8'd2;

  // Base TCP header length, in 32-bit words
  localparam logic [3:0] BASE_HDR_WORDS = 4'd5;

  // Parse phase codes
  localparam logic [1:0] PHASE_KIND = 2'd0;
  localparam logic [1:0] PHASE_LEN  = 2'd1;
  localparam logic [1:0] PHASE_BODY = 2'd2;

  // Body byte counter saturates here: only the first two MSS bytes matter
  localparam logic [1:0] BODY_IDX_SAT = 2'd2;

  // Running parser state for one segment
  typedef struct packed {
    logic [5:0]  bytes_left;
    logic [1:0]  phase;
    logic        is_mss;
    logic [5:0]  body_left;
    logic [1:0]  body_idx;
    logic [5:0]  total_len;
    logic [15:0] mss_capture;
    logic        mss_found;
    logic        unsup;
    logic        bad;
  } parse_state_t;

  // One result beat
  typedef struct packed {
    logic [5:0]  options_length;
    logic        mss_found;
    logic [15:0] mss_value;
    logic        unsupported_seen;
    logic        malformed;
  } result_t;

endpackage

[hdl/tcp_option_parser_unit.sv]
// Top level of the TCP options parser: input register, parser state,
// result register. Depends on tcpop_pkg and tcpop_step.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  req_type, data_offset, option_byte
//   out      out_valid / out_stall options_length, mss_found, mss_value,
//                                  unsupported_seen, malformed
//
// One beat per cycle on the input while in_stall is low; the result for
// the beat that ends the area passes the input register, then the parser
// update into the result register. The parser update is shallow logic.
// Synchronous active-high rst clears the parser state and both valids.
// in_stall rises only while a beat waits in the input register and the
// result register holds a stalled result.
module tcp_option_parser_unit #(
  parameter int MAX_OPTION_BYTES = tcpop_pkg::MAX_OPTION_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [3:0]  data_offset,
  input  logic [7:0]  option_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  options_length,
  output logic        mss_found,
  output logic [15:0] mss_value,
  output logic        unsupported_seen,
  output logic        malformed
);

  logic                    q_valid;
  logic                    q_req_type;
  logic [3:0]              q_data_offset;
  logic [7:0]              q_option_byte;
  tcpop_pkg::parse_state_t st;
  tcpop_pkg::parse_state_t st_next;
  logic                    emit;
  tcpop_pkg::result_t      result;
  tcpop_pkg::result_t      res_q;
  logic                    out_blocked;
  logic                    process;
  logic                    in_take;

  assign out_blocked = out_valid && out_stall;
  assign process     = q_valid && !out_blocked;
  assign in_stall    = q_valid && out_blocked;
  assign in_take     = in_valid && !in_stall;

  tcpop_step #(
    .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
  ) u_step (
    .st          (st),
    .req_type    (q_req_type),
    .data_offset (q_data_offset),
    .option_byte (q_option_byte),
    .st_next     (st_next),
    .emit        (emit),
    .result      (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      q_req_type    <= req_type;
      q_data_offset <= data_offset;
      q_option_byte <= option_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (process) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      res_q <= result;
    end
  end

  assign options_length   = res_q.options_length;
  assign mss_found        = res_q.mss_found;
  assign mss_value        = res_q.mss_value;
  assign unsupported_seen = res_q.unsupported_seen;
  assign malformed        = res_q.malformed;

endmodule

[hdl/tcpop_step.sv]
// Per-beat update of the TCP options parser: next state and result.
// Purely combinational; depends on tcpop_pkg.
module tcpop_step #(
  parameter int MAX_OPTION_BYTES = tcpop_pkg::MAX_OPTION_BYTES_DEF
) (
  input  tcpop_pkg::parse_state_t st,
  input  logic                    req_type,
  input  logic [3:0]              data_offset,
  input  logic [7:0]              option_byte,
  output tcpop_pkg::parse_state_t st_next,
  output logic                    emit,
  output tcpop_pkg::result_t      result
);

  logic [5:0] raw_len;
  logic [5:0] area_len;
  logic [5:0] left;
  logic [8:0] len_limit;

  // Area length: offset*4 - 20, zero for short offsets, capped
  always_comb begin
    if (data_offset >= tcpop_pkg::BASE_HDR_WORDS) begin
      raw_len = {data_offset, 2'b00} - {tcpop_pkg::BASE_HDR_WORDS, 2'b00};
    end else begin
      raw_len = 6'd0;
    end
    if (raw_len > 6'(MAX_OPTION_BYTES)) begin
      area_len = 6'(MAX_OPTION_BYTES);
    end else begin
      area_len = raw_len;
    end
  end

  assign left      = st.bytes_left - 6'd1;
  assign len_limit = {3'b000, left} + {1'b0, tcpop_pkg::OPT_HDR_BYTES};

  // State update for start and byte beats
  always_comb begin
    st_next = st;
    emit    = 1'b0;
    if (req_type == tcpop_pkg::REQ_START) begin
      st_next           = '0;
      st_next.total_len = area_len;
      st_next.bytes_left = area_len;
      emit              = (area_len == 6'd0);
    end else if (st.bytes_left != 6'd0) begin
      st_next.bytes_left = left;
      if (!st.bad) begin
        unique case (st.phase)
          tcpop_pkg::PHASE_KIND: begin
            if (option_byte != tcpop_pkg::KIND_EOL && option_byte != tcpop_pkg::KIND_NOP) begin
              st_next.is_mss = (option_byte == tcpop_pkg::KIND_MSS);
              if (option_byte != tcpop_pkg::KIND_MSS) begin
                st_next.unsup = 1'b1;
              end
              if (left == 6'd0) begin
                st_next.bad = 1'b1;
              end else begin
                st_next.phase = tcpop_pkg::PHASE_LEN;
              end
            end
          end
          tcpop_pkg::PHASE_LEN: begin
            // Length counts kind and length bytes; body must fit the area
            if (option_byte < tcpop_pkg::OPT_HDR_BYTES || {1'b0, option_byte} > len_limit) begin
              st_next.bad   = 1'b1;
              st_next.phase = tcpop_pkg::PHASE_KIND;
            end else begin
              st_next.body_left = 6'(option_byte - tcpop_pkg::OPT_HDR_BYTES);
              st_next.body_idx  = 2'd0;
              st_next.phase     = (option_byte == tcpop_pkg::OPT_HDR_BYTES) ?
                                  tcpop_pkg::PHASE_KIND : tcpop_pkg::PHASE_BODY;
            end
          end
          tcpop_pkg::PHASE_BODY: begin
            // First two MSS body bytes assemble big-endian
            if (st.is_mss && st.body_idx != tcpop_pkg::BODY_IDX_SAT) begin
              st_next.mss_capture = {st.mss_capture[7:0], option_byte};
              if (st.body_idx == 2'd1) begin
                st_next.mss_found = 1'b1;
              end
            end
            if (st.body_idx != tcpop_pkg::BODY_IDX_SAT) begin
              st_next.body_idx = st.body_idx + 2'd1;
            end
            st_next.body_left = st.body_left - 6'd1;
            if (st.body_left == 6'd1) begin
              st_next.phase = tcpop_pkg::PHASE_KIND;
            end
          end
          default: begin
            st_next.phase = tcpop_pkg::PHASE_KIND;
          end
        endcase
      end
      // Last byte of the area closes the segment
      if (left == 6'd0) begin
        st_next.phase     = tcpop_pkg::PHASE_KIND;
        st_next.body_left = 6'd0;
        emit              = 1'b1;
      end
    end
  end

  // Result fields come from the updated state
  always_comb begin
    result.options_length   = st_next.total_len;
    result.mss_found        = st_next.mss_found;
    result.mss_value        = st_next.mss_capture;
    result.unsupported_seen = st_next.unsup;
    result.malformed        = st_next.bad;
  end

endmodule
